// File: hdl/pcc_pkg.sv
// Shared types and constants for the parity constraint checker.
// No dependencies; used by parity_constraint_checker_unit.
`default_nettype none

package pcc_pkg;

  // Width of an input position field
  localparam int unsigned POS_W = 10;
  localparam int unsigned CNT_W = 16;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_REDUCE = 6'b000100,
    S_FREQ   = 6'b001000,
    S_FWAIT  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  // Which root lookup the sequencer is on, one-hot
  typedef enum logic [4:0] {
    ST_ROOT_L  = 5'b00001,  // root of left
    ST_CHECK   = 5'b00010,  // root of the clash partner of left
    ST_JOIN1   = 5'b00100,  // root of first merge partner, then link
    ST_ROOT_LN = 5'b01000,  // root of left's opposite node
    ST_JOIN2   = 5'b10000   // root of second merge partner, then link
  } step_t;

endpackage

`default_nettype wire

// File: hdl/parity_constraint_checker_unit.sv
// Parity constraint checker: doubled union-find over a parent memory.
// Depends on pcc_pkg (types, constants).
//
// Usage:
//   Input words (left_pos, right_pos, is_odd) enter on in_valid/in_ready.
//   Each word gives one result word (accepted, accepted_count, conflict_seen)
//   on out_valid/out_ready. Positions are wrapped modulo NODES.
//   Words are handled one at a time; in_ready is high only while the
//   sequencer is idle.
//   Per word: position reduction (reciprocal multiply, then subtract),
//   five root lookups through the single-read parent memory, each a read
//   request in FREQ and then FWAIT, which walks the parent chain to the
//   root, then DONE posts the result and the sequencer returns to IDLE
//   for the next word. A contradiction is posted after two lookups.
//   Once a contradiction has been latched, a word goes from IDLE straight
//   to DONE, with no reduction and no lookups.
//   Reset: a clearing pass writes every parent entry to point at itself,
//   with in_ready low; counter and latch clear at once.
//   Stall: a finished result waits in DONE until the output register is free.
`default_nettype none

module parity_constraint_checker_unit #(
  parameter int unsigned NODES = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [pcc_pkg::POS_W-1:0] left_pos,
  input  wire logic [pcc_pkg::POS_W-1:0] right_pos,
  input  wire logic                      is_odd,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           accepted,
  output logic [pcc_pkg::CNT_W-1:0]      accepted_count,
  output logic                           conflict_seen
);

  localparam int unsigned AW     = $clog2(2 * NODES);
  localparam int unsigned DEPTH  = 2 * NODES;
  localparam logic [AW-1:0] NODES_A = AW'(NODES);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);
  // reciprocal of NODES, exact quotient for any POS_W-bit position
  localparam int unsigned RED_SH = pcc_pkg::POS_W + $clog2(NODES);
  localparam int unsigned RED_MW = pcc_pkg::POS_W + 2;
  localparam int unsigned RED_PW = pcc_pkg::POS_W + RED_MW;
  localparam longint unsigned RED_M_L =
    ((64'd1 << RED_SH) + 64'(NODES) - 64'd1) / 64'(NODES);
  localparam logic [RED_PW-1:0] RED_M = RED_PW'(RED_M_L);

  pcc_pkg::state_t state;
  pcc_pkg::step_t  step;

  logic [AW-1:0] parent_mem [DEPTH];
  logic [AW-1:0] rdata;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] wdata;

  logic [pcc_pkg::POS_W-1:0] lp;
  logic [pcc_pkg::POS_W-1:0] rp;
  logic                      odd;
  logic                      rphase;
  logic [pcc_pkg::POS_W-1:0] lq;
  logic [pcc_pkg::POS_W-1:0] rq;
  logic [RED_PW-1:0]         lprod;
  logic [RED_PW-1:0]         rprod;
  logic [AW-1:0]             clr_idx;
  logic [AW-1:0]             cur;
  logic [AW-1:0]             ra;
  logic                      ok;
  logic                      latch;
  logic [pcc_pkg::CNT_W-1:0] count;

  logic [AW-1:0] lnode, lnode_n, rnode, rnode_n, j1b, j2b, start;
  logic          at_root;
  logic [pcc_pkg::CNT_W-1:0] count_inc;

  // Node numbering: p is "parity of p", p+NODES is "opposite parity of p"
  always_comb begin
    lnode   = AW'(lp);
    rnode   = AW'(rp);
    lnode_n = lnode + NODES_A;
    rnode_n = rnode + NODES_A;
    j1b     = odd ? rnode_n : rnode;
    j2b     = odd ? rnode : rnode_n;
    unique case (step)
      pcc_pkg::ST_ROOT_L:  start = lnode;
      pcc_pkg::ST_CHECK:   start = j2b;
      pcc_pkg::ST_JOIN1:   start = j1b;
      pcc_pkg::ST_ROOT_LN: start = lnode_n;
      pcc_pkg::ST_JOIN2:   start = j2b;
      default:             start = lnode;
    endcase
  end

  assign at_root   = (rdata == cur);
  assign count_inc = (count == pcc_pkg::COUNT_MAX) ? count : count + 1'b1;
  assign lprod     = RED_PW'(lp) * RED_M;
  assign rprod     = RED_PW'(rp) * RED_M;

  // Read address: chain walk follows the parent just read
  always_comb begin
    raddr = start;
    if (state == pcc_pkg::S_FWAIT) begin
      raddr = rdata;
    end
  end

  // Write port: clearing pass, or linking a root to the other root
  always_comb begin
    we    = 1'b0;
    waddr = clr_idx;
    wdata = clr_idx;
    if (state == pcc_pkg::S_CLEAR) begin
      we = 1'b1;
    end else if (state == pcc_pkg::S_FWAIT && at_root && ra != cur &&
                 (step == pcc_pkg::ST_JOIN1 || step == pcc_pkg::ST_JOIN2)) begin
      we    = 1'b1;
      waddr = ra;
      wdata = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      parent_mem[waddr] <= wdata;
    end
    rdata <= parent_mem[raddr];
  end

  assign in_ready = (state == pcc_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pcc_pkg::S_CLEAR;
      step      <= pcc_pkg::ST_ROOT_L;
      clr_idx   <= '0;
      latch     <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != pcc_pkg::S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        pcc_pkg::S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_A) begin
            state <= pcc_pkg::S_IDLE;
          end
        end
        pcc_pkg::S_IDLE: begin
          if (in_valid) begin
            lp     <= left_pos;
            rp     <= right_pos;
            odd    <= is_odd;
            rphase <= 1'b0;
            step   <= pcc_pkg::ST_ROOT_L;
            if (latch) begin
              ok    <= 1'b0;
              state <= pcc_pkg::S_DONE;
            end else begin
              state <= pcc_pkg::S_REDUCE;
            end
          end
        end
        pcc_pkg::S_REDUCE: begin
          // quotient first, then subtract quotient times NODES
          if (!rphase) begin
            lq     <= pcc_pkg::POS_W'(lprod >> RED_SH);
            rq     <= pcc_pkg::POS_W'(rprod >> RED_SH);
            rphase <= 1'b1;
          end else begin
            lp    <= lp - pcc_pkg::POS_W'(32'(lq) * NODES);
            rp    <= rp - pcc_pkg::POS_W'(32'(rq) * NODES);
            state <= pcc_pkg::S_FREQ;
          end
        end
        pcc_pkg::S_FREQ: begin
          cur   <= start;
          state <= pcc_pkg::S_FWAIT;
        end
        pcc_pkg::S_FWAIT: begin
          if (!at_root) begin
            cur <= rdata;
          end else begin
            unique case (step)
              pcc_pkg::ST_ROOT_L: begin
                ra    <= cur;
                step  <= pcc_pkg::ST_CHECK;
                state <= pcc_pkg::S_FREQ;
              end
              pcc_pkg::ST_CHECK: begin
                if (cur == ra) begin
                  ok    <= 1'b0;
                  latch <= 1'b1;
                  state <= pcc_pkg::S_DONE;
                end else begin
                  step  <= pcc_pkg::ST_JOIN1;
                  state <= pcc_pkg::S_FREQ;
                end
              end
              pcc_pkg::ST_JOIN1: begin
                step  <= pcc_pkg::ST_ROOT_LN;
                state <= pcc_pkg::S_FREQ;
              end
              pcc_pkg::ST_ROOT_LN: begin
                ra    <= cur;
                step  <= pcc_pkg::ST_JOIN2;
                state <= pcc_pkg::S_FREQ;
              end
              pcc_pkg::ST_JOIN2: begin
                ok    <= 1'b1;
                count <= count_inc;
                state <= pcc_pkg::S_DONE;
              end
              default: begin
                state <= pcc_pkg::S_DONE;
              end
            endcase
          end
        end
        pcc_pkg::S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            accepted       <= ok;
            accepted_count <= count;
            conflict_seen  <= latch;
            state          <= pcc_pkg::S_IDLE;
          end
        end
        default: begin
          state <= pcc_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
